/* src/integer_to_radix_symbols_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for integer_to_radix_symbols_top
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH
`define INTEGER_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ITRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ITRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ITRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ITRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/itrs_pkg.sv */
// ----------------------------------------------------------------------------
// itrs_pkg
// Constants and helpers for the integer to radix symbols converter.
// ----------------------------------------------------------------------------
package itrs_pkg;

	// largest radix the symbol table supports
	localparam int unsigned MAX_BASE = 16;

	// configuration port
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 64;

	// register indexes (byte address / 8)
	localparam logic [1:0] REG_BASE_LENGTH  = 2'd0;
	localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

	// special characters
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;

	// symbol table: 16 bytes, symbol 0 in the low byte
	typedef logic [127:0] sym_table_t;

	function automatic logic [7:0] sym_at(input sym_table_t tbl, input logic [3:0] idx);
		sym_at = tbl[{idx, 3'b000} +: 8];
	endfunction

endpackage

/* src/integer_to_radix_symbols_top.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_symbols_top
// Converts a signed integer to its text in a configurable radix, one
// character per output transfer, sign first, most significant digit first.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------
//  config    | psel/penable/pready    | paddr, pwdata, prdata
//  input     | in_valid / in_stall    | value
//  output    | out_valid / out_stall  | out_char, last
//
//  One item at a time; in_stall stays high from acceptance of a valid radix
//  until the last character has been loaded into the output register, or
//  until the symbol check fails. Each item runs the symbol check, then the
//  restoring divider for each digit (one quotient bit a cycle), then the
//  sign for a negative value, then the emitting of each digit.
//  Radix 2 with a full-width value is the worst case.
//  Output stalls only hold the emit sequencer; an invalid base emits nothing.
//  arst_n clears control state and the configuration registers.
//
module integer_to_radix_symbols_top #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [itrs_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [itrs_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [itrs_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [VALUE_BITS-1:0]        value,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_char,
	output logic                                last
);

	import itrs_pkg::*;

	localparam int unsigned AW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int unsigned CW = $clog2(VALUE_BITS + 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_WR    = 3'd5;

	logic [4:0]            base_length_q;
	logic [63:0]           symbols_low_q;
	logic [63:0]           symbols_high_q;
	sym_table_t            tbl;

	logic [2:0]            state_q;
	logic [4:0]            div_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [3:0]            rem_q;
	logic [AW-1:0]         bit_q;
	logic [CW-1:0]         cnt_q;
	logic [3:0]            idx_q;

	logic [3:0]            digit_mem [VALUE_BITS];
	logic [3:0]            rd_q;

	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  last_q;

	logic                  cfg_wr;
	logic                  in_xfer;
	logic                  out_free;
	logic                  len_ok;
	logic                  sym_bad;
	logic [7:0]            cur_sym;
	logic [4:0]            trial;
	logic                  ge;
	logic [3:0]            rem_nx;
	logic [VALUE_BITS-1:0] mag_nx;
	logic                  bit_last;
	logic                  mem_wr;
	logic                  mem_rd;
	logic [CW-1:0]         cnt_dec;

	assign tbl      = {symbols_high_q, symbols_low_q};
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign in_xfer  = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign pready   = 1'b1;
	assign in_stall = (state_q != ST_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_length_q  <= '0;
			symbols_low_q  <= '0;
			symbols_high_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				REG_BASE_LENGTH:  base_length_q  <= pwdata[4:0];
				REG_SYMBOLS_LOW:  symbols_low_q  <= pwdata;
				REG_SYMBOLS_HIGH: symbols_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[4:3])
			REG_BASE_LENGTH:  prdata = {{(APB_DATA_W-5){1'b0}}, base_length_q};
			REG_SYMBOLS_LOW:  prdata = symbols_low_q;
			REG_SYMBOLS_HIGH: prdata = symbols_high_q;
			default:          prdata = '0;
		endcase
	end

	// radix range check at acceptance
	assign len_ok = (base_length_q >= 5'd2) && (base_length_q <= 5'(MAX_BASE));

	// symbol check: current symbol against sign chars and all later symbols
	always_comb begin
		cur_sym = sym_at(tbl, idx_q);
		sym_bad = (cur_sym == CHAR_MINUS) || (cur_sym == CHAR_PLUS);
		for (int j = 0; j < 16; j++) begin
			if ((5'(j) > {1'b0, idx_q}) && (5'(j) < div_q) &&
			    (sym_at(tbl, 4'(j)) == cur_sym))
				sym_bad = 1'b1;
		end
	end

	// restoring divider step: one quotient bit per cycle
	assign trial    = {rem_q, mag_q[VALUE_BITS-1]};
	assign ge       = (trial >= div_q);
	assign rem_nx   = ge ? 4'(trial - div_q) : trial[3:0];
	assign mag_nx   = {mag_q[VALUE_BITS-2:0], ge};
	assign bit_last = (bit_q == AW'(VALUE_BITS - 1));
	assign mem_wr   = (state_q == ST_DIV) && bit_last;
	assign mem_rd   = (state_q == ST_RD);
	assign cnt_dec  = cnt_q - 1'b1;

	// digit buffer, written LSD first, read back in reverse
	always_ff @(posedge clk) begin
		if (mem_wr)
			digit_mem[cnt_q[AW-1:0]] <= rem_nx;
		if (mem_rd)
			rd_q <= digit_mem[cnt_dec[AW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_q   <= '0;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			rem_q   <= '0;
			bit_q   <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						div_q <= base_length_q;
						neg_q <= value[VALUE_BITS-1];
						mag_q <= value[VALUE_BITS-1] ? (-value) : value;
						rem_q <= '0;
						bit_q <= '0;
						cnt_q <= '0;
						idx_q <= '0;
						if (len_ok)
							state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sym_bad)
						state_q <= ST_IDLE;
					else if (({1'b0, idx_q} + 5'd1) == div_q)
						state_q <= ST_DIV;
					else
						idx_q <= idx_q + 4'd1;
				end
				ST_DIV: begin
					mag_q <= mag_nx;
					if (bit_last) begin
						cnt_q <= cnt_q + 1'b1;
						rem_q <= '0;
						bit_q <= '0;
						if (mag_nx == '0)
							state_q <= neg_q ? ST_SIGN : ST_RD;
					end else begin
						rem_q <= rem_nx;
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_SIGN: begin
					if (out_free)
						state_q <= ST_RD;
				end
				ST_RD: begin
					cnt_q   <= cnt_dec;
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (out_free)
						state_q <= (cnt_q == '0) ? ST_IDLE : ST_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_SIGN) || (state_q == ST_WR);
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_SIGN) begin
			out_char_q <= CHAR_MINUS;
			last_q     <= 1'b0;
		end else if (out_free && state_q == ST_WR) begin
			out_char_q <= sym_at(tbl, rd_q);
			last_q     <= (cnt_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

	// checks
`include "integer_to_radix_symbols_top_assert.svh"

	`ITRS_ASSERT_IMP(a_rem_below_div, clk, arst_n, (state_q == ST_DIV), (rem_q < div_q), "remainder not below radix")
	`ITRS_ASSERT_IMP(a_div_range, clk, arst_n, (state_q == ST_DIV), (div_q >= 5'd2 && div_q <= 5'(MAX_BASE)), "divide with invalid radix")
	`ITRS_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, (cnt_q <= CW'(VALUE_BITS)), "digit count overflow")
	`ITRS_ASSERT_NXT(a_last_char, clk, arst_n, (state_q == ST_WR && out_free && cnt_q == '0), (state_q == ST_IDLE && out_valid_q && last_q), "final character not flagged")

endmodule
